// ----- sv/sqhdf_pkg.sv -----
// ----------------------------------------------------------------------------
// sqhdf_pkg
// Shared constants for the sequence hole duplicate filter.
// ----------------------------------------------------------------------------
package sqhdf_pkg;

    localparam int FLOW_SLOTS_DEF     = 16;
    localparam int HOLES_PER_FLOW_DEF = 8;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic [1:0] V_PASS    = 2'd0;
    localparam logic [1:0] V_DELIVER = 2'd1;
    localparam logic [1:0] V_BUFFER  = 2'd2;
    localparam logic [1:0] V_DROP    = 2'd3;

    localparam logic [1:0] REL_NONE  = 2'd0;
    localparam logic [1:0] REL_ALL   = 2'd1;
    localparam logic [1:0] REL_BOUND = 2'd2;

    // outcome of the hole list update
    localparam logic [1:0] M_NONE       = 2'd0;
    localparam logic [1:0] M_FIRST      = 2'd1;
    localparam logic [1:0] M_OTHER      = 2'd2;
    localparam logic [1:0] M_SPLIT_FULL = 2'd3;

    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 40;
    localparam int HOLE_W     = 64;

endpackage

// ----- sv/sqhdf_ram.sv -----
// ----------------------------------------------------------------------------
// sqhdf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sqhdf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- sv/sequence_hole_duplicate_filter.sv -----
// ----------------------------------------------------------------------------
// sequence_hole_duplicate_filter
// Per-flow sequence hole tracker giving pass/deliver/buffer/drop verdicts.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  s (in)   | in  | i_s_tvalid/o_s_tready | tuser: operation; tdata: five-tuple, seq range
//  m (out)  | out | o_m_tvalid/i_m_tready | tdata: verdict, release, bound, slot
//  cfg      | in  | i_cfg_we           | i_cfg_wdata: enable
//
// timer ticks and packets passed without a flow search give their result in the cycle
// after the beat. a packet takes a flow search over the slots and a classify step, and
// for a packet behind the head of line a load of the flow's holes, a scan, a
// write-back where the hole list changes, and a finish step.
// one item at a time; the hole list is walked with one compare per cycle.
// reset clears the flow valid bits at once; no clearing pass is needed.
// a result waiting on i_m_tready holds off the next input beat.
module sequence_hole_duplicate_filter #(
    parameter int FLOW_SLOTS     = sqhdf_pkg::FLOW_SLOTS_DEF,
    parameter int HOLES_PER_FLOW = sqhdf_pkg::HOLES_PER_FLOW_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_wdata,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // protocol, src_addr, dst_addr, src_port, dst_port, first_seq, end_seq
    input  logic [sqhdf_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // operation
    input  logic                              i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // verdict, release_mode, release_bound, flow_slot
    output logic [sqhdf_pkg::OUT_DATA_W-1:0]  o_m_tdata
);

    localparam int SW    = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
    localparam int HW    = (HOLES_PER_FLOW > 1) ? $clog2(HOLES_PER_FLOW) : 1;
    localparam int CW    = $clog2(HOLES_PER_FLOW + 1);
    localparam int DEPTH = FLOW_SLOTS * HOLES_PER_FLOW;
    localparam int AW    = $clog2(DEPTH > 1 ? DEPTH : 2);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRCH  = 4'd1;
    localparam logic [3:0] S_CLASS = 4'd2;
    localparam logic [3:0] S_LOAD  = 4'd3;
    localparam logic [3:0] S_SCANI = 4'd4;
    localparam logic [3:0] S_CHECK = 4'd5;
    localparam logic [3:0] S_SCANK = 4'd6;
    localparam logic [3:0] S_WB    = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    localparam logic [SW-1:0] LAST_SLOT = SW'(FLOW_SLOTS - 1);
    localparam logic [CW-1:0] HMAX      = CW'(HOLES_PER_FLOW);

    // control
    logic [3:0]    r_state;
    logic          r_en;
    logic          r_ov;
    logic          r_valid [FLOW_SLOTS];

    // per-flow context
    logic          r_udp_f [FLOW_SLOTS];
    logic [31:0]   r_src   [FLOW_SLOTS];
    logic [31:0]   r_dst   [FLOW_SLOTS];
    logic [31:0]   r_pp    [FLOW_SLOTS];
    logic [31:0]   r_hol   [FLOW_SLOTS];
    logic [31:0]   r_floor [FLOW_SLOTS];
    logic          r_buf   [FLOW_SLOTS];
    logic [CW-1:0] r_cnt   [FLOW_SLOTS];

    // working copy of one flow's holes
    logic [31:0]   r_wf [HOLES_PER_FLOW];
    logic [31:0]   r_wl [HOLES_PER_FLOW];

    // current item
    logic          r_udp;
    logic [31:0]   r_sa, r_da, r_ppk, r_s, r_e;
    logic [SW-1:0] r_idx, r_slot, r_free;
    logic          r_have_free;
    logic [CW-1:0] r_n, r_j, r_i, r_k, r_newcnt;
    logic          r_first_hit, r_split;
    logic [31:0]   r_hold, r_bound;
    logic [1:0]    r_mres;

    // result register
    logic [1:0]    r_verdict, r_mode;
    logic [31:0]   r_obound;
    logic [3:0]    r_oslot;

    logic          c_hit, c_free_now;
    logic [SW-1:0] c_fs;
    logic [31:0]   c_hol, c_floor;
    logic [CW-1:0] c_n, c_src;
    logic [sqhdf_pkg::HOLE_W-1:0] c_wb;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [sqhdf_pkg::HOLE_W-1:0] ram_wdata, ram_rdata;

    wire        in_op    = i_s_tuser;
    wire [7:0]  in_proto = i_s_tdata[7:0];
    wire [31:0] in_s     = i_s_tdata[135:104];
    wire [31:0] in_e     = i_s_tdata[167:136];

    function automatic logic [AW-1:0] hole_addr(input logic [SW-1:0] slot,
                                                input logic [CW-1:0] idx);
        hole_addr = AW'(AW'(slot) * AW'(HOLES_PER_FLOW) + AW'(idx));
    endfunction

    assign o_s_tready = (r_state == S_IDLE) && !r_ov;
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {r_oslot, r_obound, r_mode, r_verdict};

    assign c_hol   = r_hol[r_slot];
    assign c_floor = r_floor[r_slot];
    assign c_n     = r_cnt[r_slot];

    always_comb begin
        c_hit = r_valid[r_idx] && (r_udp_f[r_idx] == r_udp) && (r_src[r_idx] == r_sa) &&
                (r_dst[r_idx] == r_da) && (r_pp[r_idx] == r_ppk);
        c_free_now = !r_valid[r_idx] && !r_have_free;
        c_fs = r_have_free ? r_free : r_idx;
    end

    // new list entry at position r_j during write-back
    // a shrunk hole below r_i is written back in place
    always_comb begin
        if (r_split) begin
            c_src = CW'(r_j - CW'(1));
        end else if (r_j < r_i) begin
            c_src = r_j;
        end else begin
            c_src = CW'(r_j + r_k - r_i);
        end
        if (r_split && (r_j == r_i)) begin
            c_wb = {r_wf[r_i[HW-1:0]], r_s - 32'd1};
        end else if (r_split && (r_j == CW'(r_i + CW'(1)))) begin
            c_wb = {r_e + 32'd1, r_hold};
        end else begin
            c_wb = {r_wf[c_src[HW-1:0]], r_wl[c_src[HW-1:0]]};
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = hole_addr(r_slot, r_j);
        ram_wdata = c_wb;
        ram_raddr = hole_addr(r_slot, r_j);
        case (r_state)
            S_CLASS: begin
                // append a hole past the head of line
                ram_waddr = hole_addr(r_slot, c_n);
                ram_wdata = {c_hol, r_s - 32'd1};
                ram_we    = (r_s != c_hol) && !(r_s < c_floor) && !(r_s < c_hol) &&
                            (c_n < HMAX);
            end
            S_WB: begin
                ram_we = (r_j < r_newcnt);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    sqhdf_ram #(
        .WIDTH (sqhdf_pkg::HOLE_W),
        .DEPTH (DEPTH)
    ) u_holes (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_en    <= 1'b0;
            r_ov    <= 1'b0;
            for (int f = 0; f < FLOW_SLOTS; f++) begin
                r_valid[f] <= 1'b0;
            end
        end else begin
            if (r_ov && i_m_tready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                r_en <= i_cfg_wdata;
                if (!i_cfg_wdata) begin
                    for (int f = 0; f < FLOW_SLOTS; f++) begin
                        r_valid[f] <= 1'b0;
                    end
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid && o_s_tready) begin
                        r_udp       <= (in_proto == sqhdf_pkg::PROTO_UDP);
                        r_sa        <= i_s_tdata[39:8];
                        r_da        <= i_s_tdata[71:40];
                        r_ppk       <= {i_s_tdata[87:72], i_s_tdata[103:88]};
                        r_s         <= in_s;
                        r_e         <= in_e;
                        r_idx       <= '0;
                        r_have_free <= 1'b0;
                        r_verdict   <= sqhdf_pkg::V_PASS;
                        r_mode      <= sqhdf_pkg::REL_NONE;
                        r_obound    <= '0;
                        r_oslot     <= '0;
                        if (in_op) begin
                            if (r_en) begin
                                r_mode <= sqhdf_pkg::REL_ALL;
                                for (int f = 0; f < FLOW_SLOTS; f++) begin
                                    if (r_valid[f]) begin
                                        r_cnt[f]   <= '0;
                                        r_floor[f] <= r_hol[f];
                                    end
                                end
                            end
                            r_ov <= 1'b1;
                        end else if (!r_en || ((in_proto != sqhdf_pkg::PROTO_TCP) &&
                                               (in_proto != sqhdf_pkg::PROTO_UDP)) ||
                                     (in_e + 32'd1 == in_s)) begin
                            r_ov <= 1'b1;
                        end else begin
                            r_state <= S_SRCH;
                        end
                    end
                end
                S_SRCH: begin
                    if (c_hit) begin
                        r_slot  <= r_idx;
                        r_state <= S_CLASS;
                    end else begin
                        if (c_free_now) begin
                            r_have_free <= 1'b1;
                            r_free      <= r_idx;
                        end
                        if (r_idx == LAST_SLOT) begin
                            if (r_have_free || c_free_now) begin
                                r_valid[c_fs] <= 1'b1;
                                r_udp_f[c_fs] <= r_udp;
                                r_src[c_fs]   <= r_sa;
                                r_dst[c_fs]   <= r_da;
                                r_pp[c_fs]    <= r_ppk;
                                r_hol[c_fs]   <= r_s;
                                r_floor[c_fs] <= r_s;
                                r_buf[c_fs]   <= 1'b0;
                                r_cnt[c_fs]   <= '0;
                                r_slot        <= c_fs;
                                r_state       <= S_CLASS;
                            end else begin
                                // table full
                                r_ov    <= 1'b1;
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_idx <= SW'(r_idx + SW'(1));
                        end
                    end
                end
                S_CLASS: begin
                    r_oslot <= 4'(r_slot);
                    if (r_s == c_hol) begin
                        r_hol[r_slot] <= r_e + 32'd1;
                        r_verdict     <= r_buf[r_slot] ? sqhdf_pkg::V_BUFFER :
                                                         sqhdf_pkg::V_DELIVER;
                        r_ov          <= 1'b1;
                        r_state       <= S_IDLE;
                    end else if (r_s < c_floor) begin
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_s < c_hol) begin
                        r_n     <= c_n;
                        r_j     <= '0;
                        r_state <= S_LOAD;
                    end else begin
                        if (c_n < HMAX) begin
                            r_cnt[r_slot] <= CW'(c_n + CW'(1));
                            r_buf[r_slot] <= 1'b1;
                            r_verdict     <= sqhdf_pkg::V_BUFFER;
                        end
                        r_hol[r_slot] <= r_e + 32'd1;
                        r_ov          <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                S_LOAD: begin
                    // read issued at r_j lands in the next cycle
                    if (r_j != '0) begin
                        r_wf[HW'(r_j - CW'(1))] <= ram_rdata[63:32];
                        r_wl[HW'(r_j - CW'(1))] <= ram_rdata[31:0];
                    end
                    if (r_j == r_n) begin
                        r_j     <= '0;
                        r_state <= S_SCANI;
                    end else begin
                        r_j <= CW'(r_j + CW'(1));
                    end
                end
                S_SCANI: begin
                    if (r_j == '0) begin
                        r_first_hit <= (r_wf[0] >= r_s);
                    end
                    if (r_j == r_n) begin
                        r_mres  <= sqhdf_pkg::M_NONE;
                        r_state <= S_FIN;
                    end else if (r_wl[r_j[HW-1:0]] >= r_s) begin
                        r_i     <= r_j;
                        r_state <= S_CHECK;
                    end else begin
                        r_j <= CW'(r_j + CW'(1));
                    end
                end
                S_CHECK: begin
                    r_split <= 1'b0;
                    if (r_wf[r_i[HW-1:0]] > r_e) begin
                        r_mres  <= sqhdf_pkg::M_NONE;
                        r_state <= S_FIN;
                    end else if ((r_wf[r_i[HW-1:0]] < r_s) && (r_wl[r_i[HW-1:0]] > r_e)) begin
                        if (r_n >= HMAX) begin
                            r_mres  <= sqhdf_pkg::M_SPLIT_FULL;
                            r_state <= S_FIN;
                        end else begin
                            r_split  <= 1'b1;
                            r_hold   <= r_wl[r_i[HW-1:0]];
                            r_newcnt <= CW'(r_n + CW'(1));
                            r_mres   <= sqhdf_pkg::M_OTHER;
                            r_j      <= r_i;
                            r_state  <= S_WB;
                        end
                    end else if (r_wf[r_i[HW-1:0]] < r_s) begin
                        // shrink the tail of this hole, removal starts after it
                        r_wl[r_i[HW-1:0]] <= r_s - 32'd1;
                        r_j     <= r_i;
                        r_i     <= CW'(r_i + CW'(1));
                        r_k     <= CW'(r_i + CW'(1));
                        r_state <= S_SCANK;
                    end else begin
                        r_j     <= r_i;
                        r_k     <= r_i;
                        r_state <= S_SCANK;
                    end
                end
                S_SCANK: begin
                    if ((r_k < r_n) && (r_wl[r_k[HW-1:0]] <= r_e)) begin
                        r_k <= CW'(r_k + CW'(1));
                    end else begin
                        if ((r_k < r_n) && (r_wf[r_k[HW-1:0]] <= r_e)) begin
                            r_wf[r_k[HW-1:0]] <= r_e + 32'd1;
                        end
                        r_newcnt <= CW'(r_n - (r_k - r_i));
                        r_mres   <= r_first_hit ? sqhdf_pkg::M_FIRST : sqhdf_pkg::M_OTHER;
                        r_state  <= S_WB;
                    end
                end
                S_WB: begin
                    if (r_j < r_newcnt) begin
                        if (r_j == '0) begin
                            r_bound <= c_wb[63:32];
                        end
                        r_j <= CW'(r_j + CW'(1));
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    case (r_mres)
                        sqhdf_pkg::M_FIRST: begin
                            r_cnt[r_slot] <= r_newcnt;
                            r_verdict     <= sqhdf_pkg::V_DELIVER;
                            if (r_buf[r_slot]) begin
                                if (r_newcnt == '0) begin
                                    r_mode <= sqhdf_pkg::REL_ALL;
                                end else begin
                                    r_mode   <= sqhdf_pkg::REL_BOUND;
                                    r_obound <= r_bound;
                                end
                            end
                        end
                        sqhdf_pkg::M_OTHER: begin
                            r_cnt[r_slot] <= r_newcnt;
                            r_verdict     <= r_buf[r_slot] ? sqhdf_pkg::V_BUFFER :
                                                             sqhdf_pkg::V_DELIVER;
                        end
                        sqhdf_pkg::M_NONE: begin
                            r_verdict <= (r_e >= c_hol) ? sqhdf_pkg::V_DELIVER :
                                                          sqhdf_pkg::V_DROP;
                        end
                        default: begin
                            r_verdict <= sqhdf_pkg::V_PASS;
                        end
                    endcase
                    if (r_e >= c_hol) begin
                        r_hol[r_slot] <= r_e + 32'd1;
                    end
                    r_ov    <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_busy_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_ov)
        else $error("result posted while an item is still in work");

    a_load_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> ((r_j <= r_n) && (r_n <= HMAX)))
        else $error("hole load ran past the hole count");

    a_wb_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB) |-> (r_newcnt <= HMAX))
        else $error("hole list grew beyond its store");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> ((r_state == S_SRCH) || r_ov))
        else $error("accepted beat neither answered nor searched");

endmodule
